// ===== design/gmcc_pkg.sv =====
// types, constants and controller/datapath interface structs for the mark-compact collector
// no dependencies

package gmcc_pkg;

   localparam int MAX_NODES = 64;
   localparam int DEGREE    = 6;
   localparam int ID_W      = 6;
   localparam int CNT_W     = 7;
   localparam int SLOT_W    = $clog2(DEGREE);

   typedef logic [ID_W-1:0]   id_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef id_type [DEGREE-1:0] row_type;

   typedef enum logic [1:0] {
      KIND_WRITE   = 2'd0,
      KIND_COLLECT = 2'd1,
      KIND_READ    = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      RD_INDEX,
      RD_NODE,
      RD_SCAN,
      RD_ZERO
   } rd_sel_type;

   typedef enum logic [1:0] {
      MAP_SLOT,
      MAP_PLAYER,
      MAP_CAMERA
   } map_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ_WAIT,
      ST_POP,
      ST_FETCH,
      ST_GRAB,
      ST_VISIT,
      ST_SCAN,
      ST_MOVE,
      ST_TAIL0,
      ST_TAILG,
      ST_TAIL,
      ST_REN,
      ST_REN_GRAB,
      ST_MAP_RD,
      ST_MAP_GRAB,
      ST_REN_WR,
      ST_PMAP,
      ST_PGRAB,
      ST_CGRAB,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        load_item;
      logic        wr_item;
      logic        tbl_rd;
      rd_sel_type  rd_sel;
      logic        clear_walk;
      logic        pop;
      logic        grab_row;
      logic        visit;
      logic        compact_wr;
      logic        scan_skip;
      logic        tail_init;
      logic        tail_wr;
      logic        ren_init;
      logic        map_rd;
      map_sel_type map_sel;
      logic        map_grab;
      logic        row_wr;
      logic        grab_player;
      logic        grab_camera;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     pre_bad;
      logic     walk_bad;
      logic     stack_empty;
      logic     slot_last;
      logic     scan_end;
      logic     scan_marked;
      logic     ren_done;
      logic     rsp_free;
   } sts_type;

endpackage

// ===== design/gmcc_dpath.sv =====
// collector datapath: node table, walk stack, renumber map, mark bits, counters, result register
// depends on gmcc_pkg

module gmcc_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  gmcc_pkg::cmd_type       cmd,
   output gmcc_pkg::sts_type       sts,
   input  logic [1:0]              req_kind,
   input  logic [5:0]              req_index,
   input  logic [5:0]              req_nbr_a,
   input  logic [5:0]              req_nbr_b,
   input  logic [5:0]              req_nbr_c,
   input  logic [5:0]              req_nbr_d,
   input  logic [5:0]              req_nbr_e,
   input  logic [5:0]              req_nbr_f,
   input  logic [6:0]              req_node_total,
   input  logic [5:0]              req_player_node,
   input  logic [5:0]              req_camera_node,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [5:0]              rsp_out_a,
   output logic [5:0]              rsp_out_b,
   output logic [5:0]              rsp_out_c,
   output logic [5:0]              rsp_out_d,
   output logic [5:0]              rsp_out_e,
   output logic [5:0]              rsp_out_f,
   output logic [6:0]              rsp_kept_total,
   output logic [5:0]              rsp_new_player,
   output logic [5:0]              rsp_new_camera,
   output logic                    rsp_bad_id
);

   localparam int MAXN = gmcc_pkg::MAX_NODES;

   gmcc_pkg::row_type tbl_mem [MAXN];
   gmcc_pkg::id_type  stack_mem [MAXN];
   gmcc_pkg::id_type  map_mem [MAXN];

   gmcc_pkg::row_type  tbl_rdata_ff;
   gmcc_pkg::id_type   stack_rdata_ff;
   gmcc_pkg::id_type   map_rdata_ff;

   gmcc_pkg::kind_type kind_ff;
   gmcc_pkg::id_type   index_ff, player_ff, camera_ff;
   gmcc_pkg::row_type  nbr_ff;
   gmcc_pkg::cnt_type  count_ff;

   gmcc_pkg::row_type  row_ff, row_in;
   gmcc_pkg::slot_type slot_ff, slot_in;
   gmcc_pkg::cnt_type  top_ff, top_in, i_ff, i_in, j_ff, j_in;
   logic [MAXN-1:0]    marked_ff, marked_in;
   logic               walk_bad_ff, walk_bad_in;
   gmcc_pkg::id_type   newp_ff, newc_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   gmcc_pkg::row_type  rsp_row_ff;
   gmcc_pkg::cnt_type  rsp_kept_ff;
   gmcc_pkg::id_type   rsp_player_ff, rsp_camera_ff;
   logic               rsp_bad_ff;

   gmcc_pkg::id_type   nb;
   logic               nb_bad, push;
   gmcc_pkg::id_type   tbl_raddr, map_raddr, stack_raddr;
   logic               tbl_we;
   gmcc_pkg::id_type   tbl_waddr;
   gmcc_pkg::row_type  tbl_wdata;
   logic               stack_we;
   gmcc_pkg::id_type   stack_waddr, stack_wdata;
   logic               col_err;

   // current walk neighbour
   assign nb     = row_ff[slot_ff];
   assign nb_bad = {1'b0, nb} >= count_ff;
   assign push   = cmd.visit && !nb_bad && !marked_ff[nb]
                   && (top_ff < gmcc_pkg::CNT_W'(MAXN));

   always_comb begin
      sts.kind        = kind_ff;
      sts.pre_bad     = (count_ff == '0) || (count_ff > gmcc_pkg::CNT_W'(MAXN))
                        || ({1'b0, player_ff} >= count_ff)
                        || ({1'b0, camera_ff} >= count_ff);
      sts.walk_bad    = walk_bad_ff;
      sts.stack_empty = (top_ff == '0);
      sts.slot_last   = (slot_ff == gmcc_pkg::SLOT_W'(gmcc_pkg::DEGREE - 1));
      sts.scan_end    = (i_ff == count_ff);
      sts.scan_marked = marked_ff[i_ff[gmcc_pkg::ID_W-1:0]];
      sts.ren_done    = (i_ff >= j_ff);
      sts.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // memory address and write selection
   always_comb begin
      case (cmd.rd_sel)
         gmcc_pkg::RD_INDEX: tbl_raddr = index_ff;
         gmcc_pkg::RD_NODE:  tbl_raddr = stack_rdata_ff;
         gmcc_pkg::RD_SCAN:  tbl_raddr = i_ff[gmcc_pkg::ID_W-1:0];
         default:            tbl_raddr = '0;
      endcase
      case (cmd.map_sel)
         gmcc_pkg::MAP_PLAYER: map_raddr = player_ff;
         gmcc_pkg::MAP_CAMERA: map_raddr = camera_ff;
         default:              map_raddr = nb;
      endcase
      stack_raddr = gmcc_pkg::ID_W'(top_ff - 1'b1);

      tbl_we    = cmd.wr_item || cmd.compact_wr || cmd.tail_wr || cmd.row_wr;
      tbl_waddr = i_ff[gmcc_pkg::ID_W-1:0];
      tbl_wdata = row_ff;
      if (cmd.wr_item) begin
         tbl_waddr = index_ff;
         tbl_wdata = nbr_ff;
      end else if (cmd.compact_wr) begin
         tbl_waddr = j_ff[gmcc_pkg::ID_W-1:0];
         tbl_wdata = tbl_rdata_ff;
      end

      stack_we    = cmd.clear_walk || push;
      stack_waddr = cmd.clear_walk ? '0 : top_ff[gmcc_pkg::ID_W-1:0];
      stack_wdata = cmd.clear_walk ? player_ff : nb;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      if (cmd.tbl_rd) begin
         tbl_rdata_ff <= tbl_mem[tbl_raddr];
      end
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      if (cmd.pop) begin
         stack_rdata_ff <= stack_mem[stack_raddr];
      end
      if (cmd.compact_wr) begin
         map_mem[i_ff[gmcc_pkg::ID_W-1:0]] <= j_ff[gmcc_pkg::ID_W-1:0];
      end
      if (cmd.map_rd) begin
         map_rdata_ff <= map_mem[map_raddr];
      end
   end

   // walk and compaction state
   always_comb begin
      top_in      = top_ff;
      marked_in   = marked_ff;
      walk_bad_in = walk_bad_ff;
      slot_in     = slot_ff;
      row_in      = row_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      if (cmd.clear_walk) begin
         top_in            = gmcc_pkg::CNT_W'(1);
         marked_in         = '0;
         marked_in[0]      = 1'b1;
         marked_in[player_ff] = 1'b1;
         walk_bad_in       = 1'b0;
         i_in              = '0;
         j_in              = '0;
      end
      if (cmd.pop) begin
         top_in = top_ff - 1'b1;
      end
      if (cmd.visit && nb_bad) begin
         walk_bad_in = 1'b1;
      end
      if (push) begin
         top_in        = top_ff + 1'b1;
         marked_in[nb] = 1'b1;
      end
      if (cmd.grab_row) begin
         row_in  = tbl_rdata_ff;
         slot_in = '0;
      end
      if (cmd.map_grab) begin
         row_in[slot_ff] = map_rdata_ff;
      end
      if (cmd.visit || cmd.map_grab) begin
         slot_in = slot_ff + 1'b1;
      end
      if (cmd.scan_skip || cmd.compact_wr || cmd.tail_wr || cmd.row_wr) begin
         i_in = i_ff + 1'b1;
      end
      if (cmd.compact_wr) begin
         j_in = j_ff + 1'b1;
      end
      if (cmd.tail_init) begin
         i_in = j_ff;
      end
      if (cmd.ren_init) begin
         i_in = gmcc_pkg::CNT_W'(1);
      end
   end

   assign col_err = sts.pre_bad || walk_bad_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         marked_ff    <= '0;
         walk_bad_ff  <= 1'b0;
         slot_ff      <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         top_ff       <= top_in;
         marked_ff    <= marked_in;
         walk_bad_ff  <= walk_bad_in;
         slot_ff      <= slot_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      if (cmd.load_item) begin
         kind_ff   <= gmcc_pkg::kind_type'(req_kind);
         index_ff  <= req_index;
         nbr_ff    <= {req_nbr_f, req_nbr_e, req_nbr_d, req_nbr_c, req_nbr_b, req_nbr_a};
         count_ff  <= req_node_total;
         player_ff <= req_player_node;
         camera_ff <= req_camera_node;
      end
      if (cmd.grab_player) begin
         newp_ff <= map_rdata_ff;
      end
      if (cmd.grab_camera) begin
         // a camera node that was not kept renumbers to 0
         newc_ff <= marked_ff[camera_ff] ? map_rdata_ff : '0;
      end
      if (cmd.load_rsp) begin
         rsp_row_ff    <= '0;
         rsp_kept_ff   <= '0;
         rsp_player_ff <= '0;
         rsp_camera_ff <= '0;
         rsp_bad_ff    <= 1'b0;
         case (kind_ff)
            gmcc_pkg::KIND_READ: begin
               rsp_row_ff <= tbl_rdata_ff;
            end
            gmcc_pkg::KIND_COLLECT: begin
               rsp_bad_ff    <= col_err;
               rsp_kept_ff   <= col_err ? count_ff : j_ff;
               rsp_player_ff <= col_err ? player_ff : newp_ff;
               rsp_camera_ff <= col_err ? camera_ff : newc_ff;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_a      = rsp_row_ff[0];
   assign rsp_out_b      = rsp_row_ff[1];
   assign rsp_out_c      = rsp_row_ff[2];
   assign rsp_out_d      = rsp_row_ff[3];
   assign rsp_out_e      = rsp_row_ff[4];
   assign rsp_out_f      = rsp_row_ff[5];
   assign rsp_kept_total = rsp_kept_ff;
   assign rsp_new_player = rsp_player_ff;
   assign rsp_new_camera = rsp_camera_ff;
   assign rsp_bad_id     = rsp_bad_ff;

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> top_ff != '0)
      else $error("pop from empty walk stack");

   a_walk_start: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_walk |=> marked_ff[0] && top_ff == gmcc_pkg::CNT_W'(1))
      else $error("walk did not start with node 0 marked and root pushed");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      cmd.compact_wr |-> j_ff <= i_ff)
      else $error("compaction would overwrite an unread row");

   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

endmodule

// ===== design/gmcc_ctrl.sv =====
// collector controller: sequences decode, walk, compaction, tail fill and renumbering
// depends on gmcc_pkg

module gmcc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  gmcc_pkg::sts_type  sts,
   output gmcc_pkg::cmd_type  cmd
);

   gmcc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gmcc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.rd_sel  = gmcc_pkg::RD_INDEX;
      cmd.map_sel = gmcc_pkg::MAP_SLOT;
      req_ready   = 1'b0;
      unique case (state_ff)
         gmcc_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
            if (req_valid) begin
               state_in = gmcc_pkg::ST_DECODE;
            end
         end
         gmcc_pkg::ST_DECODE: begin
            unique case (sts.kind)
               gmcc_pkg::KIND_WRITE: begin
                  cmd.wr_item = 1'b1;
                  state_in    = gmcc_pkg::ST_FINISH;
               end
               gmcc_pkg::KIND_READ: begin
                  cmd.tbl_rd = 1'b1;
                  state_in   = gmcc_pkg::ST_READ_WAIT;
               end
               gmcc_pkg::KIND_COLLECT: begin
                  if (sts.pre_bad) begin
                     state_in = gmcc_pkg::ST_FINISH;
                  end else begin
                     cmd.clear_walk = 1'b1;
                     state_in       = gmcc_pkg::ST_POP;
                  end
               end
               default: state_in = gmcc_pkg::ST_FINISH;
            endcase
         end
         gmcc_pkg::ST_READ_WAIT: state_in = gmcc_pkg::ST_FINISH;
         gmcc_pkg::ST_POP: begin
            // a bad neighbour leaves the table untouched
            if (sts.stack_empty) begin
               state_in = sts.walk_bad ? gmcc_pkg::ST_FINISH : gmcc_pkg::ST_SCAN;
            end else begin
               cmd.pop  = 1'b1;
               state_in = gmcc_pkg::ST_FETCH;
            end
         end
         gmcc_pkg::ST_FETCH: begin
            cmd.tbl_rd = 1'b1;
            cmd.rd_sel = gmcc_pkg::RD_NODE;
            state_in   = gmcc_pkg::ST_GRAB;
         end
         gmcc_pkg::ST_GRAB: begin
            cmd.grab_row = 1'b1;
            state_in     = gmcc_pkg::ST_VISIT;
         end
         gmcc_pkg::ST_VISIT: begin
            cmd.visit = 1'b1;
            if (sts.slot_last) begin
               state_in = gmcc_pkg::ST_POP;
            end
         end
         gmcc_pkg::ST_SCAN: begin
            if (sts.scan_end) begin
               state_in = gmcc_pkg::ST_TAIL0;
            end else if (sts.scan_marked) begin
               cmd.tbl_rd = 1'b1;
               cmd.rd_sel = gmcc_pkg::RD_SCAN;
               state_in   = gmcc_pkg::ST_MOVE;
            end else begin
               cmd.scan_skip = 1'b1;
            end
         end
         gmcc_pkg::ST_MOVE: begin
            cmd.compact_wr = 1'b1;
            state_in       = gmcc_pkg::ST_SCAN;
         end
         gmcc_pkg::ST_TAIL0: begin
            cmd.tbl_rd    = 1'b1;
            cmd.rd_sel    = gmcc_pkg::RD_ZERO;
            cmd.tail_init = 1'b1;
            state_in      = gmcc_pkg::ST_TAILG;
         end
         gmcc_pkg::ST_TAILG: begin
            cmd.grab_row = 1'b1;
            state_in     = gmcc_pkg::ST_TAIL;
         end
         gmcc_pkg::ST_TAIL: begin
            if (sts.scan_end) begin
               cmd.ren_init = 1'b1;
               state_in     = gmcc_pkg::ST_REN;
            end else begin
               cmd.tail_wr = 1'b1;
            end
         end
         gmcc_pkg::ST_REN: begin
            if (sts.ren_done) begin
               state_in = gmcc_pkg::ST_PMAP;
            end else begin
               cmd.tbl_rd = 1'b1;
               cmd.rd_sel = gmcc_pkg::RD_SCAN;
               state_in   = gmcc_pkg::ST_REN_GRAB;
            end
         end
         gmcc_pkg::ST_REN_GRAB: begin
            cmd.grab_row = 1'b1;
            state_in     = gmcc_pkg::ST_MAP_RD;
         end
         gmcc_pkg::ST_MAP_RD: begin
            cmd.map_rd = 1'b1;
            state_in   = gmcc_pkg::ST_MAP_GRAB;
         end
         gmcc_pkg::ST_MAP_GRAB: begin
            cmd.map_grab = 1'b1;
            state_in     = sts.slot_last ? gmcc_pkg::ST_REN_WR : gmcc_pkg::ST_MAP_RD;
         end
         gmcc_pkg::ST_REN_WR: begin
            cmd.row_wr = 1'b1;
            state_in   = gmcc_pkg::ST_REN;
         end
         gmcc_pkg::ST_PMAP: begin
            cmd.map_rd  = 1'b1;
            cmd.map_sel = gmcc_pkg::MAP_PLAYER;
            state_in    = gmcc_pkg::ST_PGRAB;
         end
         gmcc_pkg::ST_PGRAB: begin
            cmd.grab_player = 1'b1;
            cmd.map_rd      = 1'b1;
            cmd.map_sel     = gmcc_pkg::MAP_CAMERA;
            state_in        = gmcc_pkg::ST_CGRAB;
         end
         gmcc_pkg::ST_CGRAB: begin
            cmd.grab_camera = 1'b1;
            state_in        = gmcc_pkg::ST_FINISH;
         end
         gmcc_pkg::ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = gmcc_pkg::ST_IDLE;
            end
         end
         default: state_in = gmcc_pkg::ST_IDLE;
      endcase
   end

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |=> state_ff == gmcc_pkg::ST_DECODE)
      else $error("item taken outside idle");

   a_finish_leaves: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> state_ff == gmcc_pkg::ST_IDLE)
      else $error("result loaded without returning to idle");

   a_one_table_write: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.wr_item, cmd.compact_wr, cmd.tail_wr, cmd.row_wr}) <= 1)
      else $error("two table writes in one cycle");

endmodule

// ===== design/graph_mark_compact_collector.sv =====
// top level of the graph mark-compact collector
// depends on gmcc_pkg, gmcc_ctrl, gmcc_dpath
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------------
//  req      | req_valid/req_ready  | kind, index, nbr_a..f, node_total, player, camera
//  rsp      | rsp_valid/rsp_ready  | out_a..f, kept_total, new_player, new_camera, bad
//
// collect: a walk from the player node over the reached nodes, a scan that compacts the marked rows,
// a tail fill of the rows past the kept ones, then renumbering of the kept nodes past node 0 through the map port
// reset clears the controller, mark bits and counters; table contents are kept
// a stalled result holds the result register; one item is in flight at a time

module graph_mark_compact_collector (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [5:0] req_index,
   input  logic [5:0] req_nbr_a,
   input  logic [5:0] req_nbr_b,
   input  logic [5:0] req_nbr_c,
   input  logic [5:0] req_nbr_d,
   input  logic [5:0] req_nbr_e,
   input  logic [5:0] req_nbr_f,
   input  logic [6:0] req_node_total,
   input  logic [5:0] req_player_node,
   input  logic [5:0] req_camera_node,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [5:0] rsp_out_a,
   output logic [5:0] rsp_out_b,
   output logic [5:0] rsp_out_c,
   output logic [5:0] rsp_out_d,
   output logic [5:0] rsp_out_e,
   output logic [5:0] rsp_out_f,
   output logic [6:0] rsp_kept_total,
   output logic [5:0] rsp_new_player,
   output logic [5:0] rsp_new_camera,
   output logic       rsp_bad_id
);

   gmcc_pkg::cmd_type cmd;
   gmcc_pkg::sts_type sts;

   gmcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gmcc_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_kind        (req_kind),
      .req_index       (req_index),
      .req_nbr_a       (req_nbr_a),
      .req_nbr_b       (req_nbr_b),
      .req_nbr_c       (req_nbr_c),
      .req_nbr_d       (req_nbr_d),
      .req_nbr_e       (req_nbr_e),
      .req_nbr_f       (req_nbr_f),
      .req_node_total  (req_node_total),
      .req_player_node (req_player_node),
      .req_camera_node (req_camera_node),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_a       (rsp_out_a),
      .rsp_out_b       (rsp_out_b),
      .rsp_out_c       (rsp_out_c),
      .rsp_out_d       (rsp_out_d),
      .rsp_out_e       (rsp_out_e),
      .rsp_out_f       (rsp_out_f),
      .rsp_kept_total  (rsp_kept_total),
      .rsp_new_player  (rsp_new_player),
      .rsp_new_camera  (rsp_new_camera),
      .rsp_bad_id      (rsp_bad_id)
   );

endmodule
